// ===== src/rce_pkg.sv =====
`default_nettype none
package rce_pkg;

	localparam int ALPHABET = 26;
	localparam int LW = 5;
	localparam int DEF_ROTOR_SLOTS = 8;
	localparam int DEF_REFLECTOR_SLOTS = 4;

	// command field codes
	typedef enum logic [2:0] {
		CMD_ENCIPHER  = 3'd0,
		CMD_LOAD_ROT  = 3'd1,
		CMD_LOAD_REF  = 3'd2,
		CMD_LOAD_PLUG = 3'd3,
		CMD_RESTART   = 3'd4
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ROTOR_CHOICE = 2'd0,
		CFG_START_POS    = 2'd1,
		CFG_REFL_SELECT  = 2'd2
	} cfg_idx_t;

	// work kinds queued between front and back
	typedef enum logic [2:0] {
		K_ENC,
		K_ROT,
		K_REF,
		K_PLUG,
		K_RESTART
	} kind_t;

	typedef struct packed {
		kind_t          kind;
		logic [2:0]     slot;
		logic [LW-1:0]  idx;
		logic [LW-1:0]  val;
		logic [LW-1:0]  letter;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

	typedef struct packed {
		logic [8:0]  rotor_choice;
		logic [14:0] start_positions;
		logic [1:0]  reflector_select;
	} cfg_t;

	// reduce a value below 3*26 into 0..25
	function automatic logic [LW-1:0] mod26(logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (r >= 7'(2 * ALPHABET)) r = r - 7'(2 * ALPHABET);
		if (r >= 7'(ALPHABET)) r = r - 7'(ALPHABET);
		return r[LW-1:0];
	endfunction

	// reduce a slot number modulo a small slot count
	function automatic logic [2:0] mod_slot(logic [2:0] v, int n);
		logic [2:0] r;
		r = v;
		for (int i = 0; i < 8; i++) begin
			if (int'(r) >= n) r = r - 3'(n);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/rce_ram.sv =====
`default_nettype none
module rce_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 26
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port, registered read port with hold
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/rce_front.sv =====
`default_nettype none
module rce_front #(
	parameter int ROTOR_SLOTS = rce_pkg::DEF_ROTOR_SLOTS,
	parameter int REFLECTOR_SLOTS = rce_pkg::DEF_REFLECTOR_SLOTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_stall,
	input  wire logic [2:0]       command,
	input  wire logic [2:0]       table_slot,
	input  wire logic [4:0]       entry_index,
	input  wire logic [4:0]       entry_value,
	input  wire logic [4:0]       letter,
	output      rce_pkg::q_head_t head,
	input  wire logic             pop
);
	import rce_pkg::*;

	entry_t     ent;
	logic       keep;
	logic       push;
	logic       idx_ok;
	entry_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	// classify the incoming beat; drop bad loads and unused commands
	always_comb begin
		idx_ok     = (entry_index < 5'(ALPHABET)) && (entry_value < 5'(ALPHABET));
		ent.slot   = table_slot;
		ent.idx    = entry_index;
		ent.val    = entry_value;
		ent.letter = mod26({2'b00, letter});
		ent.kind   = K_ENC;
		keep       = 1'b0;
		case (command)
			CMD_ENCIPHER: begin
				ent.kind = K_ENC;
				keep     = 1'b1;
			end
			CMD_LOAD_ROT: begin
				ent.kind = K_ROT;
				keep     = idx_ok && (int'(table_slot) < ROTOR_SLOTS);
			end
			CMD_LOAD_REF: begin
				ent.kind = K_REF;
				keep     = idx_ok && (int'(table_slot) < REFLECTOR_SLOTS);
			end
			CMD_LOAD_PLUG: begin
				ent.kind = K_PLUG;
				keep     = idx_ok;
			end
			CMD_RESTART: begin
				ent.kind = K_RESTART;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall && keep;
	assign head.valid = (cnt_q != 2'd0);
	assign head.entry = mem_q[rptr_q];

	// two-entry queue toward the back
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== src/rce_back.sv =====
`default_nettype none
module rce_back #(
	parameter int ROTOR_SLOTS = rce_pkg::DEF_ROTOR_SLOTS,
	parameter int REFLECTOR_SLOTS = rce_pkg::DEF_REFLECTOR_SLOTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rce_pkg::cfg_t    cfg,
	input  wire rce_pkg::q_head_t head,
	output      logic             pop,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic [4:0]       cipher_letter
);
	import rce_pkg::*;

	localparam int RAW = $clog2(ROTOR_SLOTS * ALPHABET);
	localparam int FAW = $clog2(REFLECTOR_SLOTS * ALPHABET);

	function automatic logic [RAW-1:0] rot_addr(logic [2:0] s, logic [LW-1:0] x);
		return RAW'(int'(s) * ALPHABET + int'(x));
	endfunction

	function automatic logic [LW-1:0] add_off(logic [LW-1:0] x, logic [LW-1:0] o);
		return mod26(7'(x) + 7'(o));
	endfunction

	function automatic logic [LW-1:0] sub_off(logic [LW-1:0] y, logic [LW-1:0] o);
		return mod26(7'(y) + 7'(ALPHABET) - 7'(o));
	endfunction

	logic                    adv;
	logic                    busy;
	logic                    is_load;
	logic                    issue;
	logic                    enc_go;
	logic                    rot_we;
	logic                    ref_we;
	logic                    plug_we;
	logic [2:0]              sl [3];
	logic [2:0]              rsl;
	logic [2:0][LW-1:0]      dig_q;
	logic [2:0][LW-1:0]      dig_nx;
	logic [2:0][LW-1:0]      off_nx;
	logic [9:1]              vld_s;
	logic [2:0][LW-1:0]      off_s [1:8];
	logic                    out_vld_q;
	logic [LW-1:0]           out_q;
	logic [LW-1:0]           rd [9];
	logic [LW-1:0]           x [1:8];
	logic [RAW-1:0]          ra [1:7];
	logic [FAW-1:0]          fa;
	logic [RAW-1:0]          rot_wa_f;
	logic [RAW-1:0]          rot_wa_i;
	logic [FAW-1:0]          ref_wa;
	entry_t                  e;

	assign e = head.entry;

	// selected slots, reduced to the slot counts
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sl[j] = mod_slot(cfg.rotor_choice[3*j +: 3], ROTOR_SLOTS);
		end
		rsl = mod_slot({1'b0, cfg.reflector_select}, REFLECTOR_SLOTS);
	end

	// issue control: loads wait until no letter is in flight
	assign adv     = !out_vld_q || !out_stall;
	assign busy    = |vld_s;
	assign is_load = (e.kind == K_ROT) || (e.kind == K_REF) || (e.kind == K_PLUG);
	assign issue   = head.valid && adv && !(is_load && busy);
	assign pop     = issue;
	assign enc_go  = issue && (e.kind == K_ENC);
	assign rot_we  = issue && (e.kind == K_ROT);
	assign ref_we  = issue && (e.kind == K_REF);
	assign plug_we = issue && (e.kind == K_PLUG);

	assign rot_wa_f = rot_addr(e.slot, e.idx);
	assign rot_wa_i = rot_addr(e.slot, e.val);
	assign ref_wa   = FAW'(int'(e.slot) * ALPHABET + int'(e.idx));

	// advance the base-26 position count and form rotor offsets
	always_comb begin
		logic c;
		c = 1'b1;
		for (int j = 0; j < 3; j++) begin
			dig_nx[j] = dig_q[j];
			if (c) begin
				if (dig_q[j] == 5'(ALPHABET - 1)) begin
					dig_nx[j] = '0;
				end else begin
					dig_nx[j] = dig_q[j] + 5'd1;
					c = 1'b0;
				end
			end
			off_nx[j] = mod26(7'(mod26(7'(cfg.start_positions[5*j +: 5]))) + 7'(dig_nx[j]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q     <= '0;
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (issue && (e.kind == K_RESTART)) dig_q <= '0;
			else if (enc_go) dig_q <= dig_nx;
			if (adv) begin
				vld_s     <= {vld_s[8:1], enc_go};
				out_vld_q <= vld_s[9];
			end
		end
	end

	// carry offsets and the result along the lookup chain
	always_ff @(posedge clk) begin
		if (adv) begin
			off_s[1] <= off_nx;
			for (int k = 2; k <= 8; k++) off_s[k] <= off_s[k-1];
			out_q <= rd[8];
		end
	end

	// letter between lookups, with rotor offsets undone and applied
	always_comb begin
		x[1] = rd[0];
		ra[1] = rot_addr(sl[0], add_off(x[1], off_s[1][0]));
		x[2] = sub_off(rd[1], off_s[2][0]);
		ra[2] = rot_addr(sl[1], add_off(x[2], off_s[2][1]));
		x[3] = sub_off(rd[2], off_s[3][1]);
		ra[3] = rot_addr(sl[2], add_off(x[3], off_s[3][2]));
		x[4] = sub_off(rd[3], off_s[4][2]);
		fa = FAW'(int'(rsl) * ALPHABET + int'(x[4]));
		x[5] = rd[4];
		ra[5] = rot_addr(sl[2], add_off(x[5], off_s[5][2]));
		x[6] = sub_off(rd[5], off_s[6][2]);
		ra[6] = rot_addr(sl[1], add_off(x[6], off_s[6][1]));
		x[7] = sub_off(rd[6], off_s[7][1]);
		ra[7] = rot_addr(sl[0], add_off(x[7], off_s[7][0]));
		x[8] = sub_off(rd[7], off_s[8][0]);
		ra[4] = '0;
	end

	// one table copy per lookup so each stage has its own read port
	rce_ram #(.WIDTH(LW), .DEPTH(ALPHABET)) u_plug_in (
		.clk, .we(plug_we), .waddr(e.idx), .wdata(e.val),
		.re(adv), .raddr(e.letter), .rdata(rd[0]));
	rce_ram #(.WIDTH(LW), .DEPTH(ROTOR_SLOTS * ALPHABET)) u_fwd0 (
		.clk, .we(rot_we), .waddr(rot_wa_f), .wdata(e.val),
		.re(adv), .raddr(ra[1]), .rdata(rd[1]));
	rce_ram #(.WIDTH(LW), .DEPTH(ROTOR_SLOTS * ALPHABET)) u_fwd1 (
		.clk, .we(rot_we), .waddr(rot_wa_f), .wdata(e.val),
		.re(adv), .raddr(ra[2]), .rdata(rd[2]));
	rce_ram #(.WIDTH(LW), .DEPTH(ROTOR_SLOTS * ALPHABET)) u_fwd2 (
		.clk, .we(rot_we), .waddr(rot_wa_f), .wdata(e.val),
		.re(adv), .raddr(ra[3]), .rdata(rd[3]));
	rce_ram #(.WIDTH(LW), .DEPTH(REFLECTOR_SLOTS * ALPHABET)) u_refl (
		.clk, .we(ref_we), .waddr(ref_wa), .wdata(e.val),
		.re(adv), .raddr(fa), .rdata(rd[4]));
	rce_ram #(.WIDTH(LW), .DEPTH(ROTOR_SLOTS * ALPHABET)) u_inv2 (
		.clk, .we(rot_we), .waddr(rot_wa_i), .wdata(e.idx),
		.re(adv), .raddr(ra[5]), .rdata(rd[5]));
	rce_ram #(.WIDTH(LW), .DEPTH(ROTOR_SLOTS * ALPHABET)) u_inv1 (
		.clk, .we(rot_we), .waddr(rot_wa_i), .wdata(e.idx),
		.re(adv), .raddr(ra[6]), .rdata(rd[6]));
	rce_ram #(.WIDTH(LW), .DEPTH(ROTOR_SLOTS * ALPHABET)) u_inv0 (
		.clk, .we(rot_we), .waddr(rot_wa_i), .wdata(e.idx),
		.re(adv), .raddr(ra[7]), .rdata(rd[7]));
	rce_ram #(.WIDTH(LW), .DEPTH(ALPHABET)) u_plug_out (
		.clk, .we(plug_we), .waddr(e.idx), .wdata(e.val),
		.re(adv), .raddr(x[8]), .rdata(rd[8]));

	assign out_valid     = out_vld_q && (ra[4] == '0);
	assign cipher_letter = out_q;
endmodule
`default_nettype wire

// ===== src/rotor_cipher_letter_engine_core.sv =====
`default_nettype none
// Channel | Handshake          | Beat fields
// in      | in_valid/in_stall  | command, table_slot, entry_index, entry_value, letter
// out     | out_valid/out_stall| cipher_letter
// cfg     | cfg_we             | cfg_index, cfg_wdata
//
// One beat per cycle sustained unless out_stall is set or a load waits; a letter
// passes nine registered table lookups (one table copy each) and the output register.
// A load waits in the queue while letters are still in the lookup chain.
// arst_n clears the queue, the position count and the lookup chain; tables hold
// whatever was last written. out_stall on a valid output holds the whole lookup chain.
module rotor_cipher_letter_engine_core #(
	parameter int ROTOR_SLOTS = rce_pkg::DEF_ROTOR_SLOTS,
	parameter int REFLECTOR_SLOTS = rce_pkg::DEF_REFLECTOR_SLOTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [2:0]  table_slot,
	input  wire logic [4:0]  entry_index,
	input  wire logic [4:0]  entry_value,
	input  wire logic [4:0]  letter,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [4:0]  cipher_letter,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_wdata
);
	import rce_pkg::*;

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROTOR_CHOICE: cfg_q.rotor_choice     <= cfg_wdata[8:0];
				CFG_START_POS:    cfg_q.start_positions  <= cfg_wdata;
				CFG_REFL_SELECT:  cfg_q.reflector_select <= cfg_wdata[1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	rce_front #(.ROTOR_SLOTS(ROTOR_SLOTS), .REFLECTOR_SLOTS(REFLECTOR_SLOTS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .table_slot,
		.entry_index, .entry_value, .letter, .head, .pop);

	rce_back #(.ROTOR_SLOTS(ROTOR_SLOTS), .REFLECTOR_SLOTS(REFLECTOR_SLOTS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .head, .pop, .out_valid, .out_stall, .cipher_letter);
endmodule
`default_nettype wire

// ===== dv/rotor_cipher_letter_engine_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rotor_cipher_letter_engine_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [2:0]  table_slot,
	input  wire logic [4:0]  entry_index,
	input  wire logic [4:0]  entry_value,
	input  wire logic [4:0]  letter,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [4:0]  cipher_letter,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_wdata,
	output int               mismatches,
	output int               letters_due
);
	import rce_pkg::*;

	localparam int ROTORS = DEF_ROTOR_SLOTS;
	localparam int REFLECTORS = DEF_REFLECTOR_SLOTS;

	logic [4:0]  rotor_tab [ROTORS*ALPHABET];
	logic [4:0]  rotor_inv [ROTORS*ALPHABET];
	logic [4:0]  refl_tab [REFLECTORS*ALPHABET];
	logic [4:0]  plug_tab [ALPHABET];
	int          msg_digit [3];
	logic [8:0]  sel_rotors;
	logic [14:0] sel_starts;
	logic [1:0]  sel_refl;
	logic [4:0]  cipher_due [$];

	// one rotor pass with the rotor turned by its offset
	function automatic int rotor_pass(logic [4:0] tab [ROTORS*ALPHABET], int slot, int x,
		int off);
		int y;
		y = tab[slot * ALPHABET + (x + off) % ALPHABET];
		return (y + ALPHABET - off) % ALPHABET;
	endfunction

	// step the message count, then run the letter through the machine
	function automatic logic [4:0] encipher_letter(logic [4:0] plain);
		int x;
		int off [3];
		int slot [3];
		bit carry;
		carry = 1;
		for (int j = 0; j < 3; j++) begin
			if (carry) begin
				msg_digit[j]++;
				carry = msg_digit[j] >= ALPHABET;
				if (carry) msg_digit[j] = 0;
			end
		end
		for (int j = 0; j < 3; j++) begin
			off[j] = ((int'(sel_starts >> (5 * j)) & 31) % ALPHABET + msg_digit[j]) % ALPHABET;
			slot[j] = (int'(sel_rotors >> (3 * j)) & 7) % ROTORS;
		end
		x = plug_tab[int'(plain) % ALPHABET];
		for (int j = 0; j < 3; j++) x = rotor_pass(rotor_tab, slot[j], x, off[j]);
		x = refl_tab[(int'(sel_refl) % REFLECTORS) * ALPHABET + x];
		for (int j = 2; j >= 0; j--) x = rotor_pass(rotor_inv, slot[j], x, off[j]);
		return plug_tab[x];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) msg_digit[j] = 0;
			sel_rotors = '0;
			sel_starts = '0;
			sel_refl = '0;
			cipher_due.delete();
			mismatches = 0;
			letters_due = 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROTOR_CHOICE: sel_rotors = cfg_wdata[8:0];
					CFG_START_POS: sel_starts = cfg_wdata;
					CFG_REFL_SELECT: sel_refl = cfg_wdata[1:0];
					default: ;
				endcase
			end
			// compare each result beat with the oldest expected letter
			if (out_valid && !out_stall) begin
				if (cipher_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected cipher_letter %0d", cipher_letter);
				end else begin
					logic [4:0] want;
					want = cipher_due.pop_front();
					if (want !== cipher_letter) begin
						mismatches++;
						if (mismatches <= 10)
							$display("cipher_letter mismatch: expected %0d actual %0d",
								want, cipher_letter);
					end
				end
			end
			// apply each accepted command beat
			if (in_valid && !in_stall) begin
				case (command)
					CMD_ENCIPHER:
						cipher_due.insert(cipher_due.size(), encipher_letter(letter));
					CMD_LOAD_ROT:
						if (table_slot < ROTORS && entry_index < ALPHABET
								&& entry_value < ALPHABET) begin
							rotor_tab[table_slot * ALPHABET + entry_index] = entry_value;
							rotor_inv[table_slot * ALPHABET + entry_value] = entry_index;
						end
					CMD_LOAD_REF:
						if (table_slot < REFLECTORS && entry_index < ALPHABET
								&& entry_value < ALPHABET)
							refl_tab[table_slot * ALPHABET + entry_index] = entry_value;
					CMD_LOAD_PLUG:
						if (entry_index < ALPHABET && entry_value < ALPHABET)
							plug_tab[entry_index] = entry_value;
					CMD_RESTART:
						for (int j = 0; j < 3; j++) msg_digit[j] = 0;
					default: ;
				endcase
			end
			letters_due = cipher_due.size();
		end
	end
endmodule
`default_nettype wire

// ===== dv/rotor_cipher_letter_engine_core_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rotor_cipher_letter_engine_core_test;
	import rce_pkg::*;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
	localparam int DRAIN_CYCLES = 16;
	localparam int STUCK_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int PHASE_BEATS = 160;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [2:0]  table_slot = '0;
	logic [4:0]  entry_index = '0;
	logic [4:0]  entry_value = '0;
	logic [4:0]  letter = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [4:0]  cipher_letter;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_wdata = '0;
	int          mismatches;
	int          letters_due;
	bit          calm = 0;
	int          stall_left = 0;
	int          stuck = 0;

	rotor_cipher_letter_engine_core dut (.*);
	rotor_cipher_letter_engine_checker checker_i (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver stalls in short random bursts
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			out_stall <= 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			stuck <= 0;
		end else if (stuck >= STUCK_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	task automatic send_beat(logic [2:0] c, logic [2:0] s, logic [4:0] i, logic [4:0] v,
		logic [4:0] l);
		in_valid <= 1;
		command <= c;
		table_slot <= s;
		entry_index <= i;
		entry_value <= v;
		letter <= l;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// drain results, then let the lookup chain settle
	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (letters_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t r, logic [14:0] d);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic set_machine(logic [14:0] rot, logic [14:0] st, logic [14:0] rf);
		write_reg(CFG_ROTOR_CHOICE, rot);
		write_reg(CFG_START_POS, st);
		write_reg(CFG_REFL_SELECT, rf);
	endtask

	// load a full permutation into a rotor slot or the plugboard
	task automatic load_permutation(logic [2:0] c, logic [2:0] s);
		int perm [ALPHABET];
		int k;
		int t;
		for (int i = 0; i < ALPHABET; i++) perm[i] = i;
		for (int i = ALPHABET - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[k];
			perm[k] = t;
		end
		for (int i = 0; i < ALPHABET; i++) send_beat(c, s, 5'(i), 5'(perm[i]), 5'($urandom));
	endtask

	function automatic logic [4:0] pick_entry();
		return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
			: 5'($urandom_range(0, 25));
	endfunction

	// mostly letters, with loads, restarts and spare codes mixed in
	task automatic random_beat();
		int r;
		r = $urandom_range(0, 99);
		if (r < 68) send_beat(CMD_ENCIPHER, 3'($urandom), 5'($urandom), 5'($urandom),
			5'($urandom));
		else if (r < 76) send_beat(CMD_LOAD_ROT, 3'($urandom), pick_entry(), pick_entry(),
			5'($urandom));
		else if (r < 83) send_beat(CMD_LOAD_REF, 3'($urandom), pick_entry(), pick_entry(),
			5'($urandom));
		else if (r < 89) send_beat(CMD_LOAD_PLUG, 3'($urandom), pick_entry(), pick_entry(),
			5'($urandom));
		else if (r < 95) send_beat(CMD_RESTART, 3'($urandom), 5'($urandom), 5'($urandom),
			5'($urandom));
		else send_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), 3'($urandom),
			5'($urandom), 5'($urandom), 5'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// fill every table before any letter reads it
		for (int s = 0; s < DEF_ROTOR_SLOTS; s++) load_permutation(CMD_LOAD_ROT, 3'(s));
		for (int s = 0; s < DEF_REFLECTOR_SLOTS; s++)
			for (int i = 0; i < ALPHABET; i++)
				send_beat(CMD_LOAD_REF, 3'(s), 5'(i), 5'($urandom_range(0, 25)), 5'($urandom));
		load_permutation(CMD_LOAD_PLUG, 3'($urandom));

		// directed: reset settings, field extremes, bad loads, spare codes
		send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'd0);
		send_beat(CMD_ENCIPHER, 3'd7, 5'd31, 5'd31, 5'd25);
		send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'd26);
		send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'd31);
		send_beat(CMD_LOAD_ROT, 3'd7, 5'd26, 5'd3, 5'd0);
		send_beat(CMD_LOAD_ROT, 3'd7, 5'd3, 5'd31, 5'd0);
		send_beat(CMD_LOAD_REF, 3'd4, 5'd0, 5'd1, 5'd0);
		send_beat(CMD_LOAD_REF, 3'd7, 5'd25, 5'd25, 5'd0);
		send_beat(CMD_LOAD_PLUG, 3'd7, 5'd31, 5'd0, 5'd0);
		send_beat(CMD_LOAD_PLUG, 3'd5, 5'd25, 5'd25, 5'd0);
		send_beat(CMD_SPARE_FIRST, 3'd0, 5'd0, 5'd0, 5'd0);
		send_beat(CMD_SPARE_MID, 3'd0, 5'd0, 5'd0, 5'd0);
		send_beat(CMD_SPARE_LAST, 3'd7, 5'd31, 5'd31, 5'd31);
		send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'd12);
		send_beat(CMD_RESTART, 3'd0, 5'd0, 5'd0, 5'd0);
		send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'd12);
		wait_idle();
		set_machine(15'h01FF, 15'h7FFF, 15'd3);
		for (int i = 0; i < 8; i++) send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'(i * 4));
		send_beat(CMD_RESTART, 3'd7, 5'd31, 5'd31, 5'd31);
		send_beat(CMD_ENCIPHER, 3'd0, 5'd0, 5'd0, 5'd25);

		// random phases, each under its own machine settings
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == 2) set_machine(15'd0, 15'd0, 15'd0);
			else if (p == 4) set_machine(15'h01FF, 15'h7FFF, 15'd3);
			else set_machine(15'($urandom), 15'($urandom), 15'($urandom));
			if (p == PHASES - 1) calm = 1;
			for (int n = 0; n < PHASE_BEATS; n++) random_beat();
		end

		wait_idle();
		if (mismatches == 0 && letters_due == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/rce_pkg.sv
src/rce_ram.sv
src/rce_front.sv
src/rce_back.sv
src/rotor_cipher_letter_engine_core.sv
dv/rotor_cipher_letter_engine_checker.sv
dv/rotor_cipher_letter_engine_core_test.sv
